// ===== rtl/cspt_pkg.sv =====
package cspt_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam logic [9:0]  QuantumRst    = 10'd100;

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_SJF  = 3'd1;
  localparam logic [2:0] POL_STCF = 3'd2;
  localparam logic [2:0] POL_RR   = 3'd3;
  localparam logic [2:0] POL_PRIO = 3'd4;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_DECIDE,
    S_WRD,
    S_WWR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [7:0]  pid;
    logic [9:0]  burst;
    logic [7:0]  prio;
    logic [15:0] wait_t;
    logic [15:0] turn;
  } entry_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic entry_t age_entry(input entry_t e);
    entry_t r;
    r        = e;
    r.wait_t = sat_inc16(e.wait_t);
    r.turn   = sat_inc16(e.turn);
    age_entry = r;
  endfunction

  // One CPU tick for the running process.
  function automatic entry_t run_entry(input entry_t e);
    entry_t r;
    r = e;
    if (e.burst != 10'd0) begin
      r.burst = e.burst - 10'd1;
      r.turn  = sat_inc16(e.turn);
    end
    run_entry = r;
  endfunction

endpackage

// ===== rtl/cspt_req_if.sv =====
interface cspt_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] pid;
  logic [9:0] burst;
  logic [7:0] priority_req;

  modport source (output valid, command, pid, burst, priority_req, input ready);
  modport sink   (input valid, command, pid, burst, priority_req, output ready);
endinterface

// ===== rtl/cspt_res_if.sv =====
interface cspt_res_if #(
  parameter int unsigned CNT_W = 5
);
  logic             valid;
  logic             ready;
  logic             status;
  logic             running_valid;
  logic [7:0]       running_pid;
  logic [9:0]       remaining_burst;
  logic             finished_valid;
  logic [7:0]       finished_pid;
  logic [15:0]      finished_wait;
  logic [15:0]      finished_turnaround;
  logic [15:0]      switch_total;
  logic [CNT_W-1:0] queue_count;
  logic             idle;

  modport source (output valid, status, running_valid, running_pid, remaining_burst,
                  finished_valid, finished_pid, finished_wait, finished_turnaround,
                  switch_total, queue_count, idle, input ready);
  modport sink   (input valid, status, running_valid, running_pid, remaining_burst,
                  finished_valid, finished_pid, finished_wait, finished_turnaround,
                  switch_total, queue_count, idle, output ready);
endinterface

// ===== rtl/cpu_scheduler_policy_tick_top.sv =====
// One request at a time: req ready only in S_IDLE, and the block takes no new
// request until the result has been accepted. An add or a tick may walk the ready
// queue memory, reading each entry and writing it back through its single address.
// Reset: asynchronous, active low; clears control, counters, running process and
// registers (policy FCFS, quantum 100). Queue memory contents are not cleared.
module cpu_scheduler_policy_tick_top import cspt_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  cspt_req_if.sink    req_i,
  cspt_res_if.source  res_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);

  state_e state_q, state_d;

  logic [2:0]       policy_q;
  logic [9:0]       quantum_q;
  logic [IW-1:0]    head_q;
  logic [CNT_W-1:0] fill_q;
  logic [CNT_W-1:0] idx_q;
  entry_t           run_q;
  logic             present_q;
  logic [9:0]       slice_q;
  logic [15:0]      switch_q;
  entry_t           new_q;
  entry_t           carry_q;
  logic             ins_q, sorted_q, keyprio_q, age_q, found_q;
  logic             status_q, fin_v_q;
  logic [7:0]       fin_pid_q;
  logic [15:0]      fin_wait_q, fin_turn_q;

  entry_t           mem [QUEUE_DEPTH];
  entry_t           rd_q;
  logic [IW-1:0]    rd_addr;
  logic [IW:0]      addr_sum;

  // Decision terms, valid in S_DECIDE with the head entry in rd_q.
  logic fill_nz, d_load_idle, d_retire, d_stcf, d_rr, d_rr_exp, d_pop, d_ins;
  logic [CNT_W-1:0] fill_left;

  // Walk terms, valid in S_WWR.
  logic       at_end, key_lt, place_new, walk_done;
  logic [9:0] key_new, key_old;
  entry_t     rd_aged, new_aged, wr_data;

  logic req_acc, res_acc;

  assign req_acc = req_i.valid & req_i.ready;
  assign res_acc = res_o.valid & res_o.ready;

  assign addr_sum = (IW+1)'(head_q) + (IW+1)'(idx_q);
  always_comb begin
    if (state_q == S_HEAD) begin
      rd_addr = head_q;
    end else if (addr_sum >= (IW+1)'(QUEUE_DEPTH)) begin
      rd_addr = IW'(addr_sum - (IW+1)'(QUEUE_DEPTH));
    end else begin
      rd_addr = addr_sum[IW-1:0];
    end
  end

  assign fill_nz     = (fill_q != '0);
  assign d_load_idle = !present_q && fill_nz;
  assign d_retire    = present_q && (run_q.burst == 10'd0);
  assign d_stcf      = present_q && !d_retire && (policy_q == POL_STCF) && fill_nz &&
                       (run_q.burst > rd_q.burst);
  assign d_rr        = present_q && !d_retire && !d_stcf && (policy_q == POL_RR);
  assign d_rr_exp    = d_rr && (slice_q >= quantum_q);
  assign d_pop       = d_load_idle || (d_retire && fill_nz) || d_stcf ||
                       (d_rr_exp && fill_nz);
  assign d_ins       = d_stcf || (d_rr_exp && fill_nz);
  assign fill_left   = fill_q - CNT_W'(d_pop);

  assign at_end    = (idx_q == fill_q);
  assign key_new   = keyprio_q ? {2'b00, new_q.prio} : new_q.burst;
  assign key_old   = keyprio_q ? {2'b00, rd_q.prio} : rd_q.burst;
  assign key_lt    = key_new < key_old;
  assign place_new = ins_q && !found_q && (at_end || (sorted_q && key_lt));
  assign rd_aged   = age_q ? age_entry(rd_q) : rd_q;
  assign new_aged  = age_q ? age_entry(new_q) : new_q;
  assign walk_done = ins_q ? at_end : (idx_q + CNT_W'(1) == fill_q);

  always_comb begin
    if (place_new) begin
      wr_data = new_aged;
    end else if (found_q) begin
      wr_data = carry_q;
    end else begin
      wr_data = rd_aged;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          if (req_i.command == CMD_TICK) begin
            state_d = S_HEAD;
          end else if (fill_q == CNT_W'(QUEUE_DEPTH)) begin
            state_d = S_OUT;
          end else begin
            state_d = S_WRD;
          end
        end
      end
      S_HEAD:   state_d = S_DECIDE;
      S_DECIDE: state_d = (d_ins || fill_left != '0) ? S_WRD : S_OUT;
      S_WRD:    state_d = S_WWR;
      S_WWR:    state_d = walk_done ? S_OUT : S_WRD;
      S_OUT: begin
        if (res_acc) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_i.ready               = (state_q == S_IDLE);
    res_o.valid               = (state_q == S_OUT);
    res_o.status              = status_q;
    res_o.running_valid       = present_q;
    res_o.running_pid         = present_q ? run_q.pid : 8'd0;
    res_o.remaining_burst     = present_q ? run_q.burst : 10'd0;
    res_o.finished_valid      = fin_v_q;
    res_o.finished_pid        = fin_pid_q;
    res_o.finished_wait       = fin_wait_q;
    res_o.finished_turnaround = fin_turn_q;
    res_o.switch_total        = switch_q;
    res_o.queue_count         = fill_q;
    res_o.idle                = !fill_nz && !present_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_HEAD || state_q == S_WRD) begin
      rd_q <= mem[rd_addr];
    end
    if (state_q == S_WWR) begin
      mem[rd_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      policy_q  <= POL_FCFS;
      quantum_q <= QuantumRst;
      head_q    <= '0;
      fill_q    <= '0;
      idx_q     <= '0;
      run_q     <= '0;
      present_q <= 1'b0;
      slice_q   <= '0;
      switch_q  <= '0;
      ins_q     <= 1'b0;
      sorted_q  <= 1'b0;
      keyprio_q <= 1'b0;
      age_q     <= 1'b0;
      found_q   <= 1'b0;
      status_q  <= 1'b0;
      fin_v_q   <= 1'b0;
      fin_pid_q <= '0;
      fin_wait_q <= '0;
      fin_turn_q <= '0;
      new_q     <= '0;
      carry_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_POLICY:  policy_q  <= cfg_data_i[2:0];
          REG_QUANTUM: quantum_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            status_q   <= 1'b0;
            fin_v_q    <= 1'b0;
            fin_pid_q  <= '0;
            fin_wait_q <= '0;
            fin_turn_q <= '0;
            idx_q      <= '0;
            found_q    <= 1'b0;
            new_q      <= '{pid: req_i.pid, burst: req_i.burst, prio: req_i.priority_req,
                            wait_t: 16'd0, turn: 16'd0};
            ins_q      <= 1'b1;
            age_q      <= 1'b0;
            sorted_q   <= (policy_q == POL_SJF) || (policy_q == POL_STCF) ||
                          (policy_q == POL_PRIO);
            keyprio_q  <= (policy_q == POL_PRIO);
            if (req_i.command == CMD_ADD && fill_q == CNT_W'(QUEUE_DEPTH)) begin
              status_q <= 1'b1;
            end
          end
        end
        S_DECIDE: begin
          ins_q     <= d_ins;
          age_q     <= 1'b1;
          sorted_q  <= d_stcf;
          keyprio_q <= 1'b0;
          new_q     <= run_q;
          fill_q    <= fill_left;
          if (d_pop) begin
            head_q <= (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IW'(1);
          end
          if (d_load_idle) begin
            run_q     <= run_entry(rd_q);
            present_q <= 1'b1;
            slice_q   <= 10'd1;
          end else if (d_retire) begin
            fin_v_q    <= 1'b1;
            fin_pid_q  <= run_q.pid;
            fin_wait_q <= run_q.wait_t;
            fin_turn_q <= run_q.turn;
            switch_q   <= sat_inc16(switch_q);
            if (fill_nz) begin
              run_q   <= run_entry(rd_q);
              slice_q <= 10'd1;
            end else begin
              run_q     <= '0;
              present_q <= 1'b0;
            end
          end else if (d_stcf || d_rr_exp) begin
            run_q    <= (d_pop) ? run_entry(rd_q) : run_entry(run_q);
            switch_q <= sat_inc16(switch_q);
            slice_q  <= 10'd1;
          end else if (present_q) begin
            run_q <= run_entry(run_q);
            if (slice_q != 10'h3FF) begin
              slice_q <= slice_q + 10'd1;
            end
          end
        end
        S_WWR: begin
          if (place_new || found_q) begin
            carry_q <= rd_aged;
          end
          if (place_new) begin
            found_q <= 1'b1;
          end
          idx_q <= idx_q + CNT_W'(1);
          if (walk_done) begin
            fill_q <= fill_q + CNT_W'(ins_q);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(QUEUE_DEPTH))
    else $error("ready queue fill exceeds depth");

  a_slice_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    present_q |-> slice_q != 10'd0)
    else $error("running process with zero slice count");

  a_empty_cpu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !present_q |-> run_q.burst == 10'd0)
    else $error("idle CPU holds a burst");

  a_full_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.command == CMD_ADD && fill_q == CNT_W'(QUEUE_DEPTH))
      |=> state_q == S_OUT && status_q)
    else $error("add to full queue not refused");
`endif

endmodule
